// ----- hw/rtl/tach_pkg.sv -----
// Shared types and constants for the engine tachometer and hour meter.
// No dependencies; imported by every other file of the block but tach_div.
package tach_pkg;

  // Field widths of the stream words
  localparam int FUNC_W    = 2;
  localparam int STAMP_W   = 32;
  localparam int RPM_W     = 26;
  localparam int CNT_W     = 32;
  localparam int IN_DATA_W = 64;
  localparam int OUT_W     = 96;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // Default width of the wrapping time arithmetic
  localparam int TIME_BITS_DEF = 32;

  // Arithmetic constants
  localparam int unsigned RPM_NUMERATOR = 60000000;
  localparam int unsigned STALL_RESET   = 5000000;
  localparam int unsigned MS_PER_MINUTE = 60000;

  // Event kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_EDGE   = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_TRIP   = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL = 2'd0,
    CFG_TRIP  = 2'd1,
    CFG_STALL = 2'd2
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic do_edge;
    logic do_sample;
    logic do_trip;
    logic rpm_go;
    logic rpm_store;
    logic timer_go;
    logic tot_go;
    logic tot_store;
    logic trip_go;
    logic trip_store;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    func_t func;
    logic  pending;
    logic  period_zero;
    logic  running;
    logic  div_done;
    logic  out_busy;
  } dp_stat_t;

endpackage

// ----- hw/rtl/tach_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Uses nothing from the package; instantiated by tach_dp.
module tach_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output logic             done
);

  localparam int CW = $clog2(WIDTH);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] quo_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] dvs_r;

  // One trial subtraction
  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  logic           fits;

  assign trial = {rem_r, quo_r[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses after the last quotient bit
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDTH - 1);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

  // A new division is only started once the previous one is finished
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  // Finished remainder is below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dvs_r != '0) |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");

endmodule

// ----- hw/rtl/tach_ctrl.sv -----
// Sequencer of the tachometer: decodes each event and steps the datapath.
// Depends on tach_pkg for the command and status structs.
module tach_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output tach_pkg::dp_cmd_t  cmd,
  input  tach_pkg::dp_stat_t stat
);
  import tach_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_RPM_DIV  = 10'b00_0000_0100,
    S_TIMER    = 10'b00_0000_1000,
    S_TOT_GO   = 10'b00_0001_0000,
    S_TOT_DIV  = 10'b00_0010_0000,
    S_TRIP_GO  = 10'b00_0100_0000,
    S_TRIP_DIV = 10'b00_1000_0000,
    S_DONE     = 10'b01_0000_0000,
    S_SPARE    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.func)
          FUNC_EDGE: begin
            cmd.do_edge = 1'b1;
            state_nxt   = S_DONE;
          end
          FUNC_SAMPLE: begin
            cmd.do_sample = 1'b1;
            state_nxt     = S_DONE;
          end
          FUNC_TRIP: begin
            cmd.do_trip = 1'b1;
            state_nxt   = S_DONE;
          end
          FUNC_TICK: begin
            if (stat.pending) begin
              cmd.rpm_go = 1'b1;
              state_nxt  = stat.period_zero ? S_TIMER : S_RPM_DIV;
            end else begin
              state_nxt = S_TIMER;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RPM_DIV: begin
        if (stat.div_done) begin
          cmd.rpm_store = 1'b1;
          state_nxt     = S_TIMER;
        end
      end
      S_TIMER: begin
        cmd.timer_go = 1'b1;
        state_nxt    = stat.running ? S_TOT_GO : S_DONE;
      end
      S_TOT_GO: begin
        cmd.tot_go = 1'b1;
        state_nxt  = S_TOT_DIV;
      end
      S_TOT_DIV: begin
        if (stat.div_done) begin
          cmd.tot_store = 1'b1;
          state_nxt     = S_TRIP_GO;
        end
      end
      S_TRIP_GO: begin
        cmd.trip_go = 1'b1;
        state_nxt   = S_TRIP_DIV;
      end
      S_TRIP_DIV: begin
        if (stat.div_done) begin
          cmd.trip_store = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted word always goes to decode next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted word not decoded");

  // The result register is never overwritten while it still holds a word
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_busy)
    else $error("result loaded while output stalled");

  // The speed division is waited out
  a_rpm_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RPM_DIV && !stat.div_done) |=> (state_r == S_RPM_DIV))
    else $error("left speed division early");

endmodule

// ----- hw/rtl/tach_dp.sv -----
// Datapath of the tachometer: event state, minute counters, registers,
// speed divider, minute divider and result register. Depends on tach_pkg and tach_div.
module tach_dp #(
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tach_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [tach_pkg::FUNC_W-1:0]   in_tuser,
  input  logic                          cfg_valid,
  input  logic [tach_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tach_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [tach_pkg::OUT_W-1:0]    out_tdata,
  input  tach_pkg::dp_cmd_t             cmd,
  output tach_pkg::dp_stat_t            stat
);
  import tach_pkg::*;

  // Working widths: time differences, speed divider
  localparam int XW = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;
  localparam int DW = (TIME_BITS > RPM_W) ? TIME_BITS : RPM_W;
  localparam int PAD_W = OUT_W - (RPM_W + 2 * CNT_W + 2);

  // Minute division: 16-bit digits, each digit by reciprocal multiplication.
  // x / 60000 = (x >> 5) / 1875; a 27-bit value times ceil(2^38 / 1875),
  // shifted down by 38, is the exact quotient.
  localparam int MD_W = 16;
  localparam int ND   = (TIME_BITS + MD_W - 1) / MD_W;
  localparam int MV_W = ND * MD_W;
  localparam int NCW  = (ND > 1) ? $clog2(ND) : 1;
  localparam logic [27:0] MIN_MAGIC = 28'd146601551;

  // Captured event
  func_t              func_r;
  logic [STAMP_W-1:0] now_us_r;
  logic [STAMP_W-1:0] now_ms_r;

  // Block state
  logic [STAMP_W-1:0] last_edge_r;
  logic [STAMP_W-1:0] prev_edge_r;
  logic               pend_r;
  logic [RPM_W-1:0]   speed_r;
  logic               run_r;
  logic               tact_r;
  logic [STAMP_W-1:0] tot_start_r;
  logic [STAMP_W-1:0] trip_start_r;
  logic [CNT_W-1:0]   tot_base_r;
  logic [CNT_W-1:0]   trip_base_r;
  logic [CNT_W-1:0]   tot_min_r;
  logic [CNT_W-1:0]   trip_min_r;
  logic [CFG_W-1:0]   stall_r;
  logic               save_r;

  // Result register
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  // Wrapping time differences
  logic [XW-1:0]        per_x, us_x, tot_x, trip_x;
  logic [TIME_BITS-1:0] period, us_diff, tot_diff, trip_diff;

  assign per_x  = XW'(last_edge_r) - XW'(prev_edge_r);
  assign us_x   = XW'(now_us_r) - XW'(last_edge_r);
  assign tot_x  = XW'(now_ms_r) - XW'(tot_start_r);
  assign trip_x = XW'(now_ms_r) - XW'(trip_start_r);

  assign period    = per_x[TIME_BITS-1:0];
  assign us_diff   = us_x[TIME_BITS-1:0];
  assign tot_diff  = tot_x[TIME_BITS-1:0];
  assign trip_diff = trip_x[TIME_BITS-1:0];

  logic period_zero, stalled;
  assign period_zero = (period == '0);
  assign stalled     = XW'(us_diff) > XW'(stall_r);

  // Speed divider: numerator over the pulse period
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_divisor, div_quo;
  logic [CNT_W-1:0] quo32;

  assign div_start    = cmd.rpm_go && !period_zero;
  assign div_dividend = DW'(RPM_NUMERATOR);
  assign div_divisor  = DW'(period);

  tach_div #(
    .WIDTH(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Minute divider: total minutes, then trip minutes
  logic                 min_start, min_busy_r, min_done_r, min_ph_r;
  logic [NCW-1:0]       min_cnt_r;
  logic [MV_W-1:0]      min_dv_r;
  logic [MD_W-1:0]      min_rem_r, min_qd_r;
  logic [CNT_W-1:0]     min_q_r;
  logic [TIME_BITS-1:0] min_dividend;
  logic [2*MD_W-1:0]    min_t, min_back, min_left;
  logic [54:0]          min_prod;

  assign min_start    = cmd.tot_go || cmd.trip_go;
  assign min_dividend = cmd.tot_go ? tot_diff : trip_diff;

  // Partial remainder with the next digit; digit quotient; new remainder
  assign min_t    = {min_rem_r, min_dv_r[MV_W-1 -: MD_W]};
  assign min_prod = 55'(min_t[31:5]) * 55'(MIN_MAGIC);
  assign min_back = 32'(min_qd_r) * 32'(MS_PER_MINUTE);
  assign min_left = min_t - min_back;

  // Per digit: multiply, then subtract and shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_busy_r <= 1'b0;
      min_done_r <= 1'b0;
      min_ph_r   <= 1'b0;
      min_cnt_r  <= '0;
    end else begin
      min_done_r <= min_busy_r && !min_start && min_ph_r && (min_cnt_r == '0);
      if (min_start) begin
        min_busy_r <= 1'b1;
        min_ph_r   <= 1'b0;
        min_cnt_r  <= NCW'(ND - 1);
        min_dv_r   <= MV_W'(min_dividend);
        min_rem_r  <= '0;
        min_q_r    <= '0;
      end else if (min_busy_r) begin
        if (!min_ph_r) begin
          min_qd_r <= min_prod[53:38];
          min_ph_r <= 1'b1;
        end else begin
          min_rem_r <= min_left[MD_W-1:0];
          min_dv_r  <= min_dv_r << MD_W;
          min_q_r   <= {min_q_r[CNT_W-MD_W-1:0], min_qd_r};
          min_ph_r  <= 1'b0;
          if (min_cnt_r == '0) begin
            min_busy_r <= 1'b0;
          end else begin
            min_cnt_r <= min_cnt_r - 1'b1;
          end
        end
      end
    end
  end

  assign quo32 = min_q_r;

  // Rebuilt minute counts
  logic [CNT_W-1:0] tot_val, trip_val;
  assign tot_val  = tot_base_r + quo32;
  assign trip_val = trip_base_r + quo32;

  // Captured event word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= func_t'(in_tuser);
      now_us_r <= in_tdata[STAMP_W-1:0];
      now_ms_r <= in_tdata[2*STAMP_W-1:STAMP_W];
    end
  end

  // State updates: register writes first, event commands after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r  <= '0;
      prev_edge_r  <= '0;
      pend_r       <= 1'b0;
      speed_r      <= '0;
      run_r        <= 1'b0;
      tact_r       <= 1'b0;
      tot_start_r  <= '0;
      trip_start_r <= '0;
      tot_base_r   <= '0;
      trip_base_r  <= '0;
      tot_min_r    <= '0;
      trip_min_r   <= '0;
      stall_r      <= CFG_W'(STALL_RESET);
      save_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TOTAL: tot_min_r  <= cfg_data;
          CFG_TRIP:  trip_min_r <= cfg_data;
          CFG_STALL: stall_r    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        save_r <= 1'b0;
      end
      if (cmd.do_edge) begin
        prev_edge_r <= last_edge_r;
        last_edge_r <= now_us_r;
        pend_r      <= 1'b1;
      end
      if (cmd.do_sample && stalled) begin
        speed_r <= '0;
        run_r   <= 1'b0;
      end
      if (cmd.do_trip) begin
        trip_min_r   <= '0;
        trip_base_r  <= '0;
        trip_start_r <= now_ms_r;
        save_r       <= 1'b1;
      end
      // Speed: zero period saturates
      if (cmd.rpm_go) begin
        pend_r <= 1'b0;
        if (period_zero) begin
          speed_r <= RPM_W'(RPM_NUMERATOR);
          run_r   <= 1'b1;
        end
      end
      if (cmd.rpm_store) begin
        speed_r <= div_quo[RPM_W-1:0];
        run_r   <= 1'b1;
      end
      // Minute timer start and stop
      if (cmd.timer_go) begin
        if (run_r && !tact_r) begin
          tact_r       <= 1'b1;
          tot_start_r  <= now_ms_r;
          trip_start_r <= now_ms_r;
          tot_base_r   <= tot_min_r;
          trip_base_r  <= trip_min_r;
        end else if (!run_r && tact_r) begin
          tact_r <= 1'b0;
        end
      end
      if (cmd.tot_store && tot_val != tot_min_r) begin
        tot_min_r <= tot_val;
        save_r    <= 1'b1;
      end
      if (cmd.trip_store && trip_val != trip_min_r) begin
        trip_min_r <= trip_val;
        save_r     <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {{PAD_W{1'b0}}, save_r, trip_min_r, tot_min_r, run_r, speed_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status back to the controller
  assign stat.func        = func_r;
  assign stat.pending     = pend_r;
  assign stat.period_zero = period_zero;
  assign stat.running     = run_r;
  assign stat.div_done    = div_done || min_done_r;
  assign stat.out_busy    = out_valid_r && !out_tready;

endmodule

// ----- hw/rtl/engine_tachometer_hour_meter_unit.sv -----
// Engine tachometer with engine hour meter. Each input word is one timed event
// (pulse edge, tick, stall check or trip reset) and yields exactly one result
// word with speed, running flag, total and trip minutes and a save request.
// Edge, stall check and trip reset go from decode to the output register load.
// A tick after an edge runs the restoring speed divider, one quotient bit per
// cycle over D = max(TIME_BITS, 26) bits, then the total and the trip minute
// divisions, each by reciprocal multiplication over N = ceil(TIME_BITS / 16)
// digits of 16 bits; the speed divider is the longest step. A zero period skips
// the speed divider; a tick on a stopped engine skips the minute divisions.
// A stalled output adds its wait. One event is worked at a time; the next word
// is accepted as soon as the result sits in the output register.
// Register writes are always accepted and load the counts at once; write them
// only while no event is in flight.
module engine_tachometer_hour_meter_unit #(
  parameter int TIME_BITS = tach_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: now_us [31:0], now_ms [63:32]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tach_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: func [1:0]
  input  logic [tach_pkg::FUNC_W-1:0]    in_tuser,
  // out_tdata: rpm_value [25:0], engine_on [26], total_count [58:27],
  // trip_count [90:59], save_request [91], zero [95:92]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tach_pkg::OUT_W-1:0]     out_tdata,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tach_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tach_pkg::CFG_W-1:0]     cfg_data
);
  import tach_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tach_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tach_dp #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ----- sim/engine_tachometer_hour_meter_unit_checker.sv -----
// Checker for the engine tachometer and hour meter: watches the event, result and
// register write channels, predicts every result word and compares it field by field.
// Depends on tach_pkg for widths, event kinds, register indexes and constants.
`timescale 1ns / 1ps

module engine_tachometer_hour_meter_unit_checker
  import tach_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [FUNC_W-1:0]    in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending_count
);

  // One result word, lowest field last so it lines up with out_tdata[91:0]
  typedef struct packed {
    logic             save;
    logic [CNT_W-1:0] trip;
    logic [CNT_W-1:0] total;
    logic             on;
    logic [RPM_W-1:0] rpm;
  } meter_word_t;

  localparam int WORD_W = $bits(meter_word_t);

  // Predicted tachometer and hour meter state
  logic [STAMP_W-1:0] lat_edge, prv_edge;
  logic               edge_seen;
  logic [RPM_W-1:0]   rpm_q;
  logic               running_q, timing_q;
  logic [STAMP_W-1:0] tot_start, trp_start;
  logic [CNT_W-1:0]   tot_base, trp_base, tot_min, trp_min;
  logic [CFG_W-1:0]   stall_lim;

  meter_word_t expected_words[$];
  int          fails  = 0;
  int          queued = 0;

  assign fail_count    = fails;
  assign pending_count = queued;

  task automatic clear_meter();
    lat_edge  = '0;
    prv_edge  = '0;
    edge_seen = 1'b0;
    rpm_q     = '0;
    running_q = 1'b0;
    timing_q  = 1'b0;
    tot_start = '0;
    trp_start = '0;
    tot_base  = '0;
    trp_base  = '0;
    tot_min   = '0;
    trp_min   = '0;
    stall_lim = STALL_RESET;
  endtask

  // Advance the predicted state by one event and build its result word
  function automatic meter_word_t step_meter(func_t kind, logic [STAMP_W-1:0] us,
                                             logic [STAMP_W-1:0] ms);
    meter_word_t        w;
    logic [STAMP_W-1:0] span;
    logic [CNT_W-1:0]   count;
    logic               save;
    save = 1'b0;
    case (kind)
      FUNC_EDGE: begin
        prv_edge  = lat_edge;
        lat_edge  = us;
        edge_seen = 1'b1;
      end
      FUNC_TICK: begin
        // speed update comes first
        if (edge_seen) begin
          edge_seen = 1'b0;
          span      = lat_edge - prv_edge;
          if (span == '0) rpm_q = RPM_W'(RPM_NUMERATOR);
          else rpm_q = RPM_W'(RPM_NUMERATOR / span);
          running_q = 1'b1;
        end
        // minute counters restart from the counts at engine start
        if (running_q && !timing_q) begin
          timing_q  = 1'b1;
          tot_start = ms;
          trp_start = ms;
          tot_base  = tot_min;
          trp_base  = trp_min;
        end else if (!running_q && timing_q) begin
          timing_q = 1'b0;
        end
        if (timing_q) begin
          count = tot_base + CNT_W'((ms - tot_start) / MS_PER_MINUTE);
          if (count != tot_min) begin
            tot_min = count;
            save    = 1'b1;
          end
          count = trp_base + CNT_W'((ms - trp_start) / MS_PER_MINUTE);
          if (count != trp_min) begin
            trp_min = count;
            save    = 1'b1;
          end
        end
      end
      FUNC_SAMPLE: begin
        // stall check, wrapping difference against the timeout
        if (STAMP_W'(us - lat_edge) > stall_lim) begin
          rpm_q     = '0;
          running_q = 1'b0;
        end
      end
      default: begin
        trp_min   = '0;
        trp_base  = '0;
        trp_start = ms;
        save      = 1'b1;
      end
    endcase
    w.rpm   = rpm_q;
    w.on    = running_q;
    w.total = tot_min;
    w.trip  = trp_min;
    w.save  = save;
    return w;
  endfunction

  task automatic load_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
    case (idx)
      CFG_TOTAL: tot_min   = value;
      CFG_TRIP:  trp_min   = value;
      CFG_STALL: stall_lim = value;
      default: ;
    endcase
  endtask

  task automatic check_word(meter_word_t exp_w, logic [OUT_W-1:0] got);
    meter_word_t got_w;
    got_w = meter_word_t'(got[WORD_W-1:0]);
    if (got_w.rpm != exp_w.rpm || got_w.on != exp_w.on || got_w.total != exp_w.total ||
        got_w.trip != exp_w.trip || got_w.save != exp_w.save ||
        got[OUT_W-1:WORD_W] != '0) begin
      if (fails < 10)
        $display("%0t mismatch: exp rpm=%0d on=%0b total=%h trip=%h save=%0b pad=0, got rpm=%0d on=%0b total=%h trip=%h save=%0b pad=%h",
                 $realtime, exp_w.rpm, exp_w.on, exp_w.total, exp_w.trip, exp_w.save,
                 got_w.rpm, got_w.on, got_w.total, got_w.trip, got_w.save,
                 got[OUT_W-1:WORD_W]);
      fails++;
    end
  endtask

  // Result words are checked before the word accepted on the same edge is queued
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_meter();
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          if (fails < 10)
            $display("%0t unexpected result word %h", $realtime, out_tdata);
          fails++;
        end else begin
          check_word(expected_words.pop_front(), out_tdata);
        end
      end
      if (cfg_valid && cfg_ready)
        load_register(cfg_idx_t'(cfg_index), cfg_data);
      if (in_tvalid && in_tready)
        expected_words.push_back(step_meter(func_t'(in_tuser), in_tdata[STAMP_W-1:0],
                                            in_tdata[2*STAMP_W-1:STAMP_W]));
    end
    queued = expected_words.size();
  end

endmodule

// ----- sim/engine_tachometer_hour_meter_unit_tb.sv -----
// Top of the engine tachometer and hour meter testbench: clock, reset, event and
// register stimulus, receiver stalls and the verdict. Depends on tach_pkg, the block
// and engine_tachometer_hour_meter_unit_checker.
`timescale 1ns / 1ps

module engine_tachometer_hour_meter_unit_tb;
  import tach_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 6;
  localparam int PHASE_EVENTS = 175;
  localparam int TAIL_CYCLES  = 120;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic [FUNC_W-1:0]    in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  int fail_count, pending_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_cnt     = 0;

  // running clocks of the simulated engine
  logic [STAMP_W-1:0] sim_us = '0;
  logic [STAMP_W-1:0] sim_ms = '0;

  engine_tachometer_hour_meter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  engine_tachometer_hour_meter_unit_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk)
    out_tready = ($urandom_range(0, 99) >= recv_idle_pct);

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one event word; called and returns at a falling edge
  task automatic send_event(func_t kind, logic [STAMP_W-1:0] us, logic [STAMP_W-1:0] ms);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {ms, us};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off the sender until every result word is back
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Register settings per phase, extremes included
  task automatic load_settings(int phase);
    case (phase)
      0: begin
        write_reg(CFG_TOTAL, 32'd0);
        write_reg(CFG_TRIP, 32'd0);
        write_reg(CFG_STALL, STALL_RESET);
      end
      1: begin
        write_reg(CFG_TOTAL, 32'hFFFF_FFFF);
        write_reg(CFG_TRIP, 32'hFFFF_FFFF);
        write_reg(CFG_STALL, 32'd1);
      end
      2: begin
        write_reg(CFG_TOTAL, $urandom);
        write_reg(CFG_TRIP, $urandom);
        write_reg(CFG_STALL, 32'hFFFF_FFFF);
      end
      3: begin
        write_reg(CFG_TOTAL, $urandom_range(0, 1000));
        write_reg(CFG_TRIP, 32'd0);
        write_reg(CFG_STALL, $urandom_range(1000, 200000));
      end
      4: begin
        write_reg(CFG_TOTAL, 32'hFFFF_FFFF - $urandom_range(0, 3));
        write_reg(CFG_TRIP, $urandom);
        write_reg(CFG_STALL, 32'd2000000);
      end
      default: begin
        write_reg(CFG_TRIP, $urandom);
        write_reg(CFG_TOTAL, $urandom);
        write_reg(CFG_STALL, $urandom_range(1, 10000000));
      end
    endcase
    cfg_valid = 1'b0;
  endtask

  // Mostly a plausible engine run, with some fully random words mixed in
  task automatic random_event();
    int unsigned pick, dus;
    func_t       kind;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_event(func_t'($urandom_range(0, 3)), $urandom, $urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = FUNC_EDGE;
      else if (pick < 75) kind = FUNC_TICK;
      else if (pick < 93) kind = FUNC_SAMPLE;
      else kind = FUNC_TRIP;
      pick = $urandom_range(0, 99);
      if (pick < 70) dus = $urandom_range(2000, 200000);
      else if (pick < 80) dus = $urandom_range(0, 50);
      else if (pick < 90) dus = $urandom_range(1000000, 12000000);
      else dus = 0;
      sim_us = sim_us + dus;
      sim_ms = sim_ms + dus / 1000;
      if ($urandom_range(0, 3) == 0) sim_ms = sim_ms + $urandom_range(0, 90000);
      send_event(kind, sim_us, sim_ms);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 33;
    recv_idle_pct = 66;

    // directed events on reset settings
    send_event(FUNC_SAMPLE, 32'd0, 32'd0);        // no stall right after reset
    send_event(FUNC_TICK, 32'd100, 32'd10);       // tick with no edge seen
    send_event(FUNC_EDGE, 32'd1000, 32'd1);
    send_event(FUNC_EDGE, 32'd1000, 32'd1);       // zero period
    send_event(FUNC_TICK, 32'd1500, 32'd2);       // saturated rpm, engine starts
    send_event(FUNC_TICK, 32'd1600, 32'd60002);   // first minute
    send_event(FUNC_TRIP, 32'd1700, 32'd60010);
    send_event(FUNC_TICK, 32'd1800, 32'd120009);
    send_event(FUNC_EDGE, 32'd21000, 32'd120010);
    send_event(FUNC_TICK, 32'd21100, 32'd180010); // 3000 rpm
    send_event(FUNC_EDGE, 32'd21001, 32'd180011); // period of one
    send_event(FUNC_TICK, 32'd21100, 32'd180012);
    send_event(FUNC_EDGE, 32'd21000, 32'd180013); // wrapped period, rpm 0
    send_event(FUNC_TICK, 32'd21100, 32'd180014);
    send_event(FUNC_SAMPLE, 32'd5021000, 32'd185000); // exactly at the timeout
    send_event(FUNC_SAMPLE, 32'd5021001, 32'd185001); // just past it
    send_event(FUNC_TICK, 32'd5021100, 32'd250000);   // stopped, timer drops
    send_event(FUNC_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(FUNC_EDGE, 32'h0000_0063, 32'hFFFF_FFFF); // period across wrap
    send_event(FUNC_TICK, 32'h0000_0070, 32'hFFFF_FFF0);
    send_event(FUNC_TICK, 32'h0000_0080, 32'h0000_EA50); // minute across ms wrap
    send_event(FUNC_TRIP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_event(FUNC_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001);
    sim_us = 32'd1000;
    sim_ms = 32'd100;

    // random phases, registers rewritten while idle in between
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      load_settings(phase);
      case (phase / 2)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_EVENTS) random_event();
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tach_pkg.sv
hw/rtl/tach_div.sv
hw/rtl/tach_ctrl.sv
hw/rtl/tach_dp.sv
hw/rtl/engine_tachometer_hour_meter_unit.sv
sim/engine_tachometer_hour_meter_unit_checker.sv
sim/engine_tachometer_hour_meter_unit_tb.sv
